FILE: rtl/core/tcpq_pkg.sv
// Package for the two-class priority queue: sizes, item structs, codes and
// the command and status structs between controller and datapath.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package tcpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_BITS = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int LIM_W       = 5;
  localparam int CMP_W       = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd3;

  // Operation codes of an input item.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // First-byte type codes that mark a video message.
  localparam logic [7:0] TYPE_VIDEO_A = 8'h01;
  localparam logic [7:0] TYPE_VIDEO_B = 8'h02;

  // Event codes of a result item.
  localparam logic [1:0] EV_DROP   = 2'd0;
  localparam logic [1:0] EV_POP    = 2'd1;
  localparam logic [1:0] EV_ACCEPT = 2'd2;
  localparam logic [1:0] EV_EMPTY  = 2'd3;

  typedef struct packed {
    logic                   kind;
    logic [HANDLE_BITS-1:0] handle;
    logic [7:0]             first_byte;
    logic                   has_payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             event_res;
    logic [HANDLE_BITS-1:0] out_handle;
    logic                   from_high;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic load;  // capture the input item
    logic emit;  // produce one result and update the queues
  } cmd_t;

  typedef struct packed {
    logic slot_free;  // output register can take a result this cycle
    logic last;       // the result about to be produced ends the item
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/tcpq_ctrl.sv
// Controller of the two-class priority queue: a two-state sequencer.
// Depends on tcpq_pkg for the command and status structs.
`default_nettype none

module tcpq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire tcpq_pkg::stat_t stat_i,
  output tcpq_pkg::cmd_t      cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WORK = 1'b1;

  logic state_q, state_d;

  always_comb begin
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    cmd_o.emit = (state_q == S_WORK) && stat_i.slot_free;
    state_d    = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.load) state_d = S_WORK;
      end
      S_WORK: begin
        if (cmd_o.emit && stat_i.last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tcpq_dp.sv
// Datapath of the two-class priority queue: item register, both rings with
// their pointers and counts, result selection and the output register.
// Depends on tcpq_pkg for sizes, codes and structs.
`default_nettype none

module tcpq_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tcpq_pkg::cmd_t               cmd_i,
  output tcpq_pkg::stat_t                   stat_o,
  input  wire tcpq_pkg::in_item_t           in_item_i,
  input  wire logic [tcpq_pkg::LIM_W-1:0]   limit_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output tcpq_pkg::out_item_t               out_item_o
);

  localparam int PtrW = tcpq_pkg::PTR_W;
  localparam int CntW = tcpq_pkg::CNT_W;
  localparam int CmpW = tcpq_pkg::CMP_W;
  localparam int HW   = tcpq_pkg::HANDLE_BITS;
  localparam int QD   = tcpq_pkg::QUEUE_DEPTH;

  tcpq_pkg::in_item_t  item_q;
  tcpq_pkg::out_item_t res, out_q;
  logic                out_valid_q;

  logic [HW-1:0]   hi_ring [QD];
  logic [HW-1:0]   lo_ring [QD];
  logic [PtrW-1:0] hi_head_q, hi_tail_q, lo_head_q, lo_tail_q;
  logic [CntW-1:0] hi_cnt_q, lo_cnt_q;

  logic                       video, is_push, drop;
  logic [CntW-1:0]            sel_cnt;
  logic [tcpq_pkg::LIM_W-1:0] lim_eff;
  logic                       do_hi_take, do_lo_take, do_hi_put, do_lo_put;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(QD - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    video = item_q.has_payload && ((item_q.first_byte == tcpq_pkg::TYPE_VIDEO_A) ||
                                   (item_q.first_byte == tcpq_pkg::TYPE_VIDEO_B));
    is_push = (item_q.kind == tcpq_pkg::KIND_PUSH);
    sel_cnt = video ? lo_cnt_q : hi_cnt_q;
    // A limit of zero behaves as one, so the drop run always ends.
    lim_eff = (limit_i == '0) ? tcpq_pkg::LIM_W'(1) : limit_i;
    drop = (video && (CmpW'(sel_cnt) >= CmpW'(lim_eff))) || (sel_cnt == CntW'(QD));

    res            = '0;
    do_hi_take     = 1'b0;
    do_lo_take     = 1'b0;
    do_hi_put      = 1'b0;
    do_lo_put      = 1'b0;
    if (is_push) begin
      res.from_high = !video;
      if (drop) begin
        res.event_res  = tcpq_pkg::EV_DROP;
        res.out_handle = video ? lo_ring[lo_head_q] : hi_ring[hi_head_q];
        res.last       = 1'b0;
        do_lo_take     = video;
        do_hi_take     = !video;
      end else begin
        res.event_res = tcpq_pkg::EV_ACCEPT;
        res.last      = 1'b1;
        do_lo_put     = video;
        do_hi_put     = !video;
      end
    end else begin
      res.last = 1'b1;
      if (hi_cnt_q != '0) begin
        res.event_res  = tcpq_pkg::EV_POP;
        res.out_handle = hi_ring[hi_head_q];
        res.from_high  = 1'b1;
        do_hi_take     = 1'b1;
      end else if (lo_cnt_q != '0) begin
        res.event_res  = tcpq_pkg::EV_POP;
        res.out_handle = lo_ring[lo_head_q];
        do_lo_take     = 1'b1;
      end else begin
        res.event_res = tcpq_pkg::EV_EMPTY;
      end
    end
  end

  assign stat_o.slot_free = !out_valid_q || !out_stall_i;
  assign stat_o.last      = res.last;
  assign out_valid_o      = out_valid_q;
  assign out_item_o       = out_q;

  // Payload storage without reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_item_i;
    if (cmd_i.emit) out_q <= res;
    if (cmd_i.emit && do_hi_put) hi_ring[hi_tail_q] <= item_q.handle;
    if (cmd_i.emit && do_lo_put) lo_ring[lo_tail_q] <= item_q.handle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hi_head_q   <= '0;
      hi_tail_q   <= '0;
      hi_cnt_q    <= '0;
      lo_head_q   <= '0;
      lo_tail_q   <= '0;
      lo_cnt_q    <= '0;
    end else begin
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        if (do_hi_take) begin
          hi_head_q <= next_ptr(hi_head_q);
          hi_cnt_q  <= hi_cnt_q - 1'b1;
        end
        if (do_lo_take) begin
          lo_head_q <= next_ptr(lo_head_q);
          lo_cnt_q  <= lo_cnt_q - 1'b1;
        end
        if (do_hi_put) begin
          hi_tail_q <= next_ptr(hi_tail_q);
          hi_cnt_q  <= hi_cnt_q + 1'b1;
        end
        if (do_lo_put) begin
          lo_tail_q <= next_ptr(lo_tail_q);
          lo_cnt_q  <= lo_cnt_q + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/two_class_priority_queue_with_drop.sv
// Top level of the two-class priority queue with head drop.
// Depends on tcpq_pkg, tcpq_ctrl and tcpq_dp.
//
// The block keeps message handles in two rings of 16 entries. A push whose
// payload is non-empty and whose first byte is 1 or 2 is video and goes to the
// low-priority ring; every other push goes to the high-priority ring. Before a
// video push, the oldest video handles are dropped and reported while the low
// ring holds at least video_limit entries (a limit of zero acts as one), and a
// push into a full ring first drops that ring's oldest handle. A pop returns
// the head of the high ring, else the head of the low ring, else reports
// empty. Each result item carries last on the final result of its input item.
// Timing: one item is worked on at a time. An item is taken and then yields
// one result per cycle while the output is not stalled: one result for a pop
// or a push without drops, plus one for each dropped handle. The controller
// emits each result into a single output register, and a stalled output holds
// that register and pauses the sequence. The next item is taken as soon as the
// last result of the previous one sits in the output register. video_limit is
// the only register, at byte address 0 of the APB port (reset value 3), and is
// to be written only while the block is idle.
`default_nettype none

module two_class_priority_queue_with_drop (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input item channel.
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire tcpq_pkg::in_item_t             in_item_i,
  // Result item channel.
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output tcpq_pkg::out_item_t                 out_item_o,
  // Configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tcpq_pkg::APB_AW-1:0]    paddr,
  input  wire logic [tcpq_pkg::APB_DW-1:0]    pwdata,
  output logic [tcpq_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  logic [tcpq_pkg::LIM_W-1:0] limit_q;
  logic                       limit_sel;
  tcpq_pkg::cmd_t             cmd;
  tcpq_pkg::stat_t            stat;

  // The register index is the word address; byte offsets within it are ignored.
  assign limit_sel = (paddr[tcpq_pkg::APB_AW-1] == 1'b0);
  assign pready    = 1'b1;
  assign prdata    = limit_sel ? tcpq_pkg::APB_DW'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= tcpq_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && limit_sel) begin
      limit_q <= pwdata[tcpq_pkg::LIM_W-1:0];
    end
  end

  tcpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tcpq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_item_i   (in_item_i),
    .limit_i     (limit_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // An accepted item keeps the input stalled until its last result is out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an item was taken");

  // While a non-final result is shown, the item is still being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.last) |-> in_stall_o)
    else $error("input open while results of an item are still owed");

  // The input reopens only when the final result has just been registered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> (out_valid_o && out_item_o.last))
    else $error("input reopened without a final result");

endmodule

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for two_class_priority_queue_with_drop.
// Depends on tcpq_pkg and the block's RTL only; it holds its own queue predictor.

module tb;
  import tcpq_pkg::*;

  // Ring indexes inside the predictor. The index doubles as the from_high flag.
  localparam int VIDEO_Q = 0;
  localparam int PRIO_Q  = 1;

  localparam logic [APB_AW-1:0] ADDR_VIDEO_LIMIT = '0;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 55;
  // Cycles the block may still need after its last result before it is idle.
  localparam int SETTLE_CYCLES   = 8;
  // Cycles without any accepted item or register access before giving up.
  localparam int STALL_LIMIT     = 2000;

  typedef struct {
    in_item_t  item;
    bit        typed;  // 1: the single result below is known by inspection
    out_item_t want;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [APB_DW-1:0]    pwdata;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  // Predictor state: two rings of handles with read and write pointers.
  logic [HANDLE_BITS-1:0] ring_store [2][QUEUE_DEPTH];
  logic [PTR_W-1:0]       ring_rd [2];
  logic [PTR_W-1:0]       ring_wr [2];
  int                     ring_fill [2];
  int                     video_cap;

  out_item_t item_results [$];     // results of the item just accepted
  out_item_t pending_results [$];  // results still owed by the block, oldest first
  out_item_t oldest_want;

  stim_row_t directed_rows [$];

  int  fail_count;
  int  items_sent;
  int  results_seen;
  int  drops_seen;
  int  idle_cycles;
  int  burst_left;
  bit  gaps_on;
  int  rcv_mode;
  int  rcv_left;

  int  phase_limit [NUM_PHASES];
  int  push_pct    [NUM_PHASES];
  int  video_pct   [NUM_PHASES];

  two_class_priority_queue_with_drop DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Removes and returns the oldest handle of ring q.
  function automatic logic [HANDLE_BITS-1:0] take_oldest(input int q);
    logic [HANDLE_BITS-1:0] h;
    h = ring_store[q][ring_rd[q]];
    ring_rd[q]++;
    ring_fill[q]--;
    return h;
  endfunction

  // Works out every result that one input item causes and updates the rings.
  // The results land in item_results, the last one flagged.
  task automatic predict_item(input in_item_t it);
    bit   vid_push;
    int   q;
    int   cap;
    logic hi;
    item_results.delete();
    if (it.kind == KIND_PUSH) begin
      vid_push = it.has_payload &&
                 (it.first_byte == TYPE_VIDEO_A || it.first_byte == TYPE_VIDEO_B);
      q  = vid_push ? VIDEO_Q : PRIO_Q;
      hi = (q == PRIO_Q);
      if (vid_push) begin
        // A limit of zero behaves as one, so the loop always terminates.
        cap = (video_cap == 0) ? 1 : video_cap;
        while (ring_fill[q] >= cap && ring_fill[q] > 0)
          item_results.push_back('{EV_DROP, take_oldest(q), hi, 1'b0});
      end
      // A full ring gives up its oldest handle to make room.
      if (ring_fill[q] >= QUEUE_DEPTH)
        item_results.push_back('{EV_DROP, take_oldest(q), hi, 1'b0});
      ring_store[q][ring_wr[q]] = it.handle;
      ring_wr[q]++;
      ring_fill[q]++;
      item_results.push_back('{EV_ACCEPT, '0, hi, 1'b0});
    end else if (ring_fill[PRIO_Q] > 0) begin
      item_results.push_back('{EV_POP, take_oldest(PRIO_Q), 1'b1, 1'b0});
    end else if (ring_fill[VIDEO_Q] > 0) begin
      item_results.push_back('{EV_POP, take_oldest(VIDEO_Q), 1'b0, 1'b0});
    end else begin
      item_results.push_back('{EV_EMPTY, '0, 1'b0, 1'b0});
    end
    item_results[$].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered and left right after a rising
  // edge, so every input changes by a nonblocking assignment at that edge.
  // ---------------------------------------------------------------------------

  function automatic stim_row_t dir_row(input logic kind, input logic [15:0] h,
                                        input logic [7:0] fb, input logic hp,
                                        input bit typed = 1'b0,
                                        input logic [1:0] ev = EV_EMPTY,
                                        input logic hi = 1'b0);
    stim_row_t r;
    r.item  = '{kind, h, fb, hp};
    r.typed = typed;
    r.want  = '{ev, '0, hi, 1'b1};
    return r;
  endfunction

  // Random item. push_p and video_p are percentages; the rest of a push is
  // random type codes, so a few of those turn out to be video as well.
  function automatic in_item_t rand_item(input int push_p, input int video_p);
    in_item_t it;
    it.kind   = ($urandom_range(99) < push_p) ? KIND_PUSH : KIND_POP;
    it.handle = HANDLE_BITS'($urandom);
    case ($urandom_range(15))
      0: it.handle = '0;
      1: it.handle = '1;
      default: ;
    endcase
    if ($urandom_range(99) < video_p) begin
      it.has_payload = 1'b1;
      it.first_byte  = $urandom_range(1) ? TYPE_VIDEO_A : TYPE_VIDEO_B;
    end else begin
      it.has_payload = 1'($urandom);
      it.first_byte  = 8'($urandom);
    end
    return it;
  endfunction

  // Presents one item, waits for it to be taken, then records what it owes.
  // Between bursts the sender drops valid for a random gap.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    predict_item(it);
    if (typed)
      pending_results.push_back(want);
    else
      foreach (item_results[k])
        pending_results.push_back(item_results[k]);
    items_sent++;
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8))
        @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // Holds the sender off until every owed result has come out and the block
  // has had time to settle.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES)
      @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reads video_limit back and compares it with what the predictor holds.
  task automatic check_video_limit();
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, ADDR_VIDEO_LIMIT, '0, rd);
    if (rd !== APB_DW'(video_cap)) begin
      fail_count++;
      $display("%0t: video_limit readback expected %0d, got %0d", $time, video_cap, rd);
    end
  endtask

  task automatic write_video_limit(input int value);
    logic [APB_DW-1:0] rd;
    apb_access(1'b1, ADDR_VIDEO_LIMIT, APB_DW'(value), rd);
    video_cap = value & ((1 << LIM_W) - 1);
    check_video_limit();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stalls on a pattern of its own. Each stretch picks a mode: no
  // stall at all, random stalls, a fixed 5-of-8 duty pattern, or one solid stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rcv_left == 0) begin
      rcv_mode <= $urandom_range(3);
      rcv_left <= $urandom_range(5, 60);
    end else begin
      rcv_left <= rcv_left - 1;
    end
    case (rcv_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(99) < 35);
      2: out_stall <= (rcv_left[2:0] < 5);
      default: out_stall <= (rcv_left < 15);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result is held against the oldest one owed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_item.event_res == EV_DROP)
        drops_seen++;
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing owed: ev=%0d handle=%h high=%b last=%b",
                 $time, out_item.event_res, out_item.out_handle, out_item.from_high,
                 out_item.last);
      end else begin
        oldest_want = pending_results.pop_front();
        if (out_item.event_res  !== oldest_want.event_res  ||
            out_item.out_handle !== oldest_want.out_handle ||
            out_item.from_high  !== oldest_want.from_high  ||
            out_item.last       !== oldest_want.last) begin
          fail_count++;
          $display("%0t: mismatch: expected ev=%0d handle=%h high=%b last=%b", $time,
                   oldest_want.event_res, oldest_want.out_handle, oldest_want.from_high,
                   oldest_want.last);
          $display("%0t:           actual   ev=%0d handle=%h high=%b last=%b", $time,
                   out_item.event_res, out_item.out_handle, out_item.from_high,
                   out_item.last);
        end
      end
    end
  end

  // Watchdog: ends the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results still owed", $time,
               STALL_LIMIT, pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    out_stall   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    fail_count  = 0;
    items_sent  = 0;
    results_seen = 0;
    drops_seen  = 0;
    idle_cycles = 0;
    burst_left  = 0;
    gaps_on     = 1'b1;
    rcv_mode    = 0;
    rcv_left    = 0;
    ring_rd     = '{default: '0};
    ring_wr     = '{default: '0};
    ring_fill   = '{default: 0};
    video_cap   = LIMIT_RESET;

    // Directed table, run with the reset limit of three. It starts and ends on
    // an empty block, shows that a video type code without payload is not video,
    // and fills the video ring to the limit so the next two video pushes each
    // drop the oldest entry. The pops then drain the priority ring first.
    directed_rows.push_back(dir_row(KIND_POP,  16'h0000, 8'h00, 1'b0, 1, EV_EMPTY,  1'b0));
    directed_rows.push_back(dir_row(KIND_PUSH, 16'hFFFF, 8'h01, 1'b0, 1, EV_ACCEPT, 1'b1));
    directed_rows.push_back(dir_row(KIND_PUSH, 16'h0000, 8'h01, 1'b1, 1, EV_ACCEPT, 1'b0));
    directed_rows.push_back(dir_row(KIND_PUSH, 16'h8001, 8'h02, 1'b1, 1, EV_ACCEPT, 1'b0));
    directed_rows.push_back(dir_row(KIND_PUSH, 16'h1234, 8'h00, 1'b1));
    directed_rows.push_back(dir_row(KIND_PUSH, 16'h7FFE, 8'hFF, 1'b1));
    directed_rows.push_back(dir_row(KIND_PUSH, 16'h5A5A, 8'h03, 1'b1));
    directed_rows.push_back(dir_row(KIND_PUSH, 16'hA5A5, 8'h01, 1'b1));
    directed_rows.push_back(dir_row(KIND_PUSH, 16'h0F0F, 8'h02, 1'b1));
    directed_rows.push_back(dir_row(KIND_PUSH, 16'hF0F0, 8'h01, 1'b1));
    directed_rows.push_back(dir_row(KIND_PUSH, 16'h00FF, 8'h02, 1'b0));
    repeat (8)
      directed_rows.push_back(dir_row(KIND_POP, 16'hFFFF, 8'hFF, 1'b1));
    directed_rows.push_back(dir_row(KIND_POP,  16'h5555, 8'hAA, 1'b1, 1, EV_EMPTY,  1'b0));
    directed_rows.push_back(dir_row(KIND_PUSH, 16'h0001, 8'hFE, 1'b0, 1, EV_ACCEPT, 1'b1));
    directed_rows.push_back(dir_row(KIND_POP,  16'hAAAA, 8'h55, 1'b0));

    // Random phases: each sets its own video limit and traffic mix. The limits
    // cover zero (treated as one), one, the ring depth, just above it, the
    // register maximum where only a full ring drops, and two random middles.
    phase_limit = '{0, 31, 1, 16, 17, 0, 0, 3};
    phase_limit[5] = $urandom_range(2, 15);
    phase_limit[6] = $urandom_range(4, 12);
    push_pct  = '{70, 85, 60, 90, 85, 65, 55, 75};
    video_pct = '{60, 80, 70, 15, 85, 50, 40, 50};

    repeat (6)
      @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The register must come out of reset at its documented value.
    check_video_limit();

    foreach (directed_rows[r])
      send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // The register may only change while the block is idle.
      drain_block();
      write_video_limit(phase_limit[p]);
      // One phase runs the sender back to back with no gaps.
      gaps_on = (p != 3);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Now and then the sender waits for the block to empty completely.
        if ((p == 2 && i == ITEMS_PER_PHASE / 2) || $urandom_range(99) < 2)
          drain_block();
        send_item(rand_item(push_pct[p], video_pct[p]), 1'b0, '0);
      end
    end

    // Let the last results come out, then watch a while for strays.
    drain_block();
    repeat (20)
      @(posedge clk);

    $display("Covered %0d items and %0d results (%0d drops) over %0d video limit settings,",
             items_sent, results_seen, drops_seen, NUM_PHASES + 1);
    $display("including limits of zero, one, the ring depth and above, and full rings.");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
